// ===== hw/rtl/pak_block_address_and_crc_check_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block address and CRC check unit.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PAK_BLOCK_ADDRESS_AND_CRC_CHECK_MACROS_SVH
`define PAK_BLOCK_ADDRESS_AND_CRC_CHECK_MACROS_SVH

// Same-cycle implication.
`define PAK_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pak check assertion failed");

// Next-cycle implication.
`define PAK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pak check assertion failed");

`endif

// ===== hw/rtl/pak_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// pak_chk_pkg
// Types, codes, constants and the address checksum function shared by the
// block address and CRC check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pak_chk_pkg;

    // Block geometry
    localparam int unsigned BLOCK_BYTES = 32;
    localparam int unsigned BLOCK_COUNT = 2048;

    localparam logic [5:0]  BLOCK_LEN   = 6'(BLOCK_BYTES);
    localparam logic [15:0] BLOCK_LIMIT = 16'(BLOCK_COUNT);
    localparam logic [5:0]  BYTES_MAX   = 6'd63;

    // CRC-8 polynomial and the inversion mask of the absent sentinel
    localparam logic [7:0] CRC_POLY   = 8'h85;
    localparam logic [7:0] CRC_INVERT = 8'hFF;

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_RANGE    = 3'd3,
        ST_LENGTH   = 3'd4
    } status_t;

    // Request beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] block_number;
        logic [7:0]  data_byte;
    } req_t;

    // Response beat
    typedef struct packed {
        logic [15:0] address_word;
        logic [7:0]  running_crc;
        status_t     status;
        logic        check_done;
    } rsp_t;

    // Checksum weight of block bits 10 down to 0
    localparam logic [4:0] ADDR_SUM [11] = '{
        5'h01, 5'h1A, 5'h0D, 5'h1C, 5'h0E, 5'h07, 5'h19, 5'h16, 5'h0B, 5'h1F, 5'h15
    };

    // Address word: block in bits 15..5, XOR checksum in bits 4..0
    function automatic logic [15:0] make_address(input logic [15:0] block);
        logic [4:0] sum;
        sum = '0;
        for (int k = 0; k < 11; k++) begin
            if (block[10 - k]) begin
                sum = sum ^ ADDR_SUM[k];
            end
        end
        return {block[10:0], sum};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pak_chk_crc.sv =====
// ----------------------------------------------------------------------------
// pak_chk_crc
// One-byte CRC-8 update, polynomial 0x85, data shifted in MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module pak_chk_crc (
    input  wire logic [7:0] crc_in,
    input  wire logic [7:0] byte_in,
    output logic      [7:0] crc_out
);
    import pak_chk_pkg::*;

    // Eight bit steps, unrolled
    always_comb
    begin
        logic [7:0] c;
        logic       hi;
        c = crc_in;
        for (int b = 7; b >= 0; b--) begin
            hi = c[7];
            c  = {c[6:0], byte_in[b]};
            if (hi) begin
                c = c ^ CRC_POLY;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pak_block_address_and_crc_check.sv =====
// ----------------------------------------------------------------------------
// pak_block_address_and_crc_check
// Frame check for memory-card block transfers: address word with checksum,
// running CRC-8 over data bytes and a final CRC verdict per block.
// ----------------------------------------------------------------------------
// Each accepted request beat has its response in the response register on
// the next cycle; one beat per cycle is sustained while responses are read.
// The only storage on the path is that single response register, so the
// unit accepts a new beat whenever the register is empty or being read in
// the same cycle. A start beat clears the CRC and byte count and latches the
// address word, data beats run the CRC one byte per beat, and a check beat
// adds one zero byte, checks length and device byte, clears CRC and count.
`default_nettype none

module pak_block_address_and_crc_check (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire pak_chk_pkg::req_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output pak_chk_pkg::rsp_t      rsp_data
);
    import pak_chk_pkg::*;

    logic [7:0]  crc_reg,          crc_next;
    logic [5:0]  bytes_seen_reg,   bytes_seen_next;
    logic [15:0] address_hold_reg, address_hold_next;
    logic        rsp_valid_reg,    rsp_valid_next;
    rsp_t        rsp_reg,          rsp_next;

    logic       accept;
    logic [7:0] crc_feed;
    logic [7:0] crc_upd;

    // Handshake
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Check beats shift in the zero augmentation byte
    assign crc_feed = (req_data.cmd == CMD_CHECK) ? 8'h00 : req_data.data_byte;

    pak_chk_crc u_crc (
        .crc_in  (crc_reg),
        .byte_in (crc_feed),
        .crc_out (crc_upd)
    );

    // Command decode: next state and response
    always_comb
    begin
        crc_next                 = crc_reg;
        bytes_seen_next          = bytes_seen_reg;
        address_hold_next        = address_hold_reg;
        rsp_next.address_word    = address_hold_reg;
        rsp_next.running_crc     = crc_reg;
        rsp_next.status          = ST_OK;
        rsp_next.check_done      = 1'b0;

        unique case (req_data.cmd)
            CMD_START:
            begin
                crc_next        = '0;
                bytes_seen_next = '0;
                if (req_data.block_number >= BLOCK_LIMIT) begin
                    address_hold_next = '0;
                    rsp_next.status   = ST_RANGE;
                end else begin
                    address_hold_next = make_address(req_data.block_number);
                end
                rsp_next.address_word = address_hold_next;
                rsp_next.running_crc  = '0;
            end
            CMD_DATA:
            begin
                crc_next = crc_upd;
                if (bytes_seen_reg < BYTES_MAX) begin
                    bytes_seen_next = bytes_seen_reg + 6'd1;
                end
                rsp_next.running_crc = crc_upd;
            end
            CMD_CHECK:
            begin
                rsp_next.running_crc = crc_upd;
                rsp_next.check_done  = 1'b1;
                if (bytes_seen_reg != BLOCK_LEN) begin
                    rsp_next.status = ST_LENGTH;
                end else if (req_data.data_byte == crc_upd) begin
                    rsp_next.status = ST_OK;
                end else if (req_data.data_byte == (crc_upd ^ CRC_INVERT)) begin
                    rsp_next.status = ST_ABSENT;
                end else begin
                    rsp_next.status = ST_MISMATCH;
                end
                crc_next        = '0;
                bytes_seen_next = '0;
            end
            default:
            begin
                // unused command: state kept, response shows current state
            end
        endcase
    end

    // Response valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept) begin
            rsp_valid_next = 1'b1;
        end else if (rsp_ready) begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg          <= '0;
            bytes_seen_reg   <= '0;
            address_hold_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end else begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept) begin
                crc_reg          <= crc_next;
                bytes_seen_reg   <= bytes_seen_next;
                address_hold_reg <= address_hold_next;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            rsp_reg <= rsp_next;
        end
    end

    // Assertions
    `include "pak_block_address_and_crc_check_macros.svh"

    `PAK_ASSERT_IMPL(a_stall_only_when_full, !req_ready, rsp_valid_reg)
    `PAK_ASSERT_IMPL(a_verdict_not_range, rsp_valid_reg && rsp_reg.check_done, rsp_reg.status != ST_RANGE)
    `PAK_ASSERT_NEXT(a_start_clears, accept && req_data.cmd == CMD_START, crc_reg == 8'h00 && bytes_seen_reg == 6'd0)
    `PAK_ASSERT_NEXT(a_check_clears, accept && req_data.cmd == CMD_CHECK, crc_reg == 8'h00 && rsp_reg.check_done)
    `PAK_ASSERT_NEXT(a_range_zero_addr, accept && req_data.cmd == CMD_START && req_data.block_number >= BLOCK_LIMIT, address_hold_reg == 16'h0000 && rsp_reg.status == ST_RANGE)

endmodule

`default_nettype wire

// ===== sim/tb_pak_block_address_and_crc_check.sv =====
// ----------------------------------------------------------------------------
// tb_pak_block_address_and_crc_check
// Self-checking bench for the block address and CRC check unit. Request
// beats go through a valid/ready sender with random gaps. Every accepted
// beat is run through a local frame model that predicts the response beat.
// Responses are read under random backpressure and compared field by field,
// in order. Stimulus covers directed corner cases, full blocks with chosen
// verdicts, broken and over-long blocks, and random noise commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pak_block_address_and_crc_check;

    import pak_chk_pkg::*;

    // Command code the unit leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1950;
    localparam int CALM_ITEMS  = 340;
    localparam int STALL_LIMIT = 1000;

    // Checksum weight per block bit, bit 0 first
    localparam logic [4:0] SUM_WEIGHT [11] = '{
        5'h15, 5'h1F, 5'h0B, 5'h16, 5'h19, 5'h07, 5'h0E, 5'h1C, 5'h0D, 5'h1A, 5'h01
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req_data  = '0;
    logic rsp_ready = 1'b0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp_data;

    // Frame model state
    logic [7:0]  frame_crc     = '0;
    logic [5:0]  frame_count   = '0;
    logic [15:0] held_address  = '0;

    rsp_t pending_results [$];
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   idle_cycles    = 0;
    int   stall_left     = 0;
    bit   quiet          = 1'b0;

    pak_block_address_and_crc_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------------

    function automatic logic [15:0] address_with_checksum(input logic [10:0] blk);
        logic [4:0] sum;
        sum = '0;
        for (int i = 0; i < 11; i++)
        begin
            if (blk[i])
            begin
                sum ^= SUM_WEIGHT[i];
            end
        end
        return {blk, sum};
    endfunction

    // One byte into the CRC-8, MSB first
    function automatic logic [7:0] crc85_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       hi;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            hi = c[7];
            c  = {c[6:0], b[i]};
            if (hi)
            begin
                c ^= CRC_POLY;
            end
        end
        return c;
    endfunction

    // Predict the response of one request beat and advance the model
    function automatic rsp_t frame_result(input req_t r);
        rsp_t       o;
        logic [7:0] fin;
        o.address_word = held_address;
        o.running_crc  = frame_crc;
        o.status       = ST_OK;
        o.check_done   = 1'b0;
        case (r.cmd)
            CMD_START:
            begin
                frame_crc   = '0;
                frame_count = '0;
                if (r.block_number >= BLOCK_LIMIT)
                begin
                    held_address = '0;
                    o.status     = ST_RANGE;
                end
                else
                begin
                    held_address = address_with_checksum(r.block_number[10:0]);
                end
                o.address_word = held_address;
                o.running_crc  = '0;
            end
            CMD_DATA:
            begin
                frame_crc = crc85_byte(frame_crc, r.data_byte);
                if (frame_count != BYTES_MAX)
                begin
                    frame_count = frame_count + 6'd1;
                end
                o.running_crc = frame_crc;
            end
            CMD_CHECK:
            begin
                fin           = crc85_byte(frame_crc, 8'h00);
                o.running_crc = fin;
                o.check_done  = 1'b1;
                if (frame_count != BLOCK_LEN)
                begin
                    o.status = ST_LENGTH;
                end
                else if (r.data_byte == fin)
                begin
                    o.status = ST_OK;
                end
                else if (r.data_byte == (fin ^ CRC_INVERT))
                begin
                    o.status = ST_ABSENT;
                end
                else
                begin
                    o.status = ST_MISMATCH;
                end
                frame_crc   = '0;
                frame_count = '0;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Response check and request capture
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_beats
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected response beat: addr %h crc %h", rsp_data.address_word,
                           rsp_data.running_crc);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.address_word !== want.address_word)
                    begin
                        $error("address_word: expected %h, got %h", want.address_word,
                               rsp_data.address_word);
                        mismatch_count++;
                    end
                    if (rsp_data.running_crc !== want.running_crc)
                    begin
                        $error("running_crc: expected %h, got %h", want.running_crc,
                               rsp_data.running_crc);
                        mismatch_count++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        mismatch_count++;
                    end
                    if (rsp_data.check_done !== want.check_done)
                    begin
                        $error("check_done: expected %0d, got %0d", want.check_done,
                               rsp_data.check_done);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                pending_results.push_back(frame_result(req_data));
            end
        end
    end

    // Response backpressure in short random bursts
    always @(posedge clk)
    begin
        if (quiet)
        begin
            rsp_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Watchdog: cycles in a row with no beat on either channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_pak_block_address_and_crc_check: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Send one request beat, with an optional gap ahead of it
    task automatic send_beat(input logic [1:0] cmd, input logic [15:0] blk,
                             input logic [7:0] b);
        req_t r;
        r.cmd          = cmd;
        r.block_number = blk;
        r.data_byte    = b;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (cmd != CMD_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Any command, any field values
    task automatic send_noise();
        send_beat(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
    endtask

    // Start, nbytes random data beats, then a check whose device byte gives
    // the wanted verdict when the length is right
    task automatic send_block(input logic [15:0] blk, input int nbytes, input status_t verdict);
        logic [7:0] crc;
        logic [7:0] b;
        logic [7:0] dev;
        crc = '0;
        send_beat(CMD_START, blk, 8'($urandom));
        for (int i = 0; i < nbytes; i++)
        begin
            b   = 8'($urandom);
            crc = crc85_byte(crc, b);
            send_beat(CMD_DATA, 16'($urandom), b);
        end
        crc = crc85_byte(crc, 8'h00);
        case (verdict)
            ST_OK:     dev = crc;
            ST_ABSENT: dev = crc ^ CRC_INVERT;
            default:
            begin
                dev = 8'($urandom);
                while (dev == crc || dev == (crc ^ CRC_INVERT))
                begin
                    dev = 8'($urandom);
                end
            end
        endcase
        send_beat(CMD_CHECK, 16'($urandom), dev);
    endtask

    function automatic status_t random_verdict();
        case ($urandom_range(0, 2))
            0:       return ST_OK;
            1:       return ST_ABSENT;
            default: return ST_MISMATCH;
        endcase
    endfunction

    // Mostly in-range block numbers, some anywhere in 16 bits
    function automatic logic [15:0] random_block();
        if ($urandom_range(0, 7) == 0)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, BLOCK_COUNT - 1));
    endfunction

    // Stop sending and let every expected response come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, range limit, unused command, short checks
    task automatic test_directed_corners();
        send_beat(CMD_START, 16'd0, 8'hFF);
        send_beat(CMD_START, 16'd2047, 8'h00);
        send_beat(CMD_START, 16'd2048, 8'h5A);
        send_beat(CMD_DATA, 16'hFFFF, 8'h00);
        send_beat(CMD_DATA, 16'h0000, 8'hFF);
        send_beat(CMD_UNUSED, 16'hFFFF, 8'hFF);
        send_beat(CMD_CHECK, 16'h0000, 8'h00);
        send_beat(CMD_CHECK, 16'hFFFF, 8'hFF);
        send_beat(CMD_START, 16'hFFFF, 8'h00);
        send_beat(CMD_START, 16'h0555, 8'h00);
        send_beat(CMD_DATA, 16'h0000, 8'h80);
        send_beat(CMD_UNUSED, 16'h0000, 8'h00);
        send_beat(CMD_START, 16'h02AA, 8'hFF);
        send_beat(CMD_DATA, 16'h0000, 8'h01);
        send_beat(CMD_CHECK, 16'h0000, 8'h00);
        send_beat(CMD_START, 16'h0400, 8'h00);
        send_beat(CMD_START, 16'h0001, 8'h00);
        send_beat(CMD_START, 16'h8000, 8'h00);
    endtask

    // Full blocks for each verdict, wrong lengths and count saturation
    task automatic test_block_verdicts();
        send_block(16'd0, BLOCK_BYTES, ST_OK);
        send_block(16'd2047, BLOCK_BYTES, ST_ABSENT);
        send_block(16'd1234, BLOCK_BYTES, ST_MISMATCH);
        send_block(16'd3000, BLOCK_BYTES, ST_OK);
        send_block(16'd7, BLOCK_BYTES - 1, ST_OK);
        send_block(16'd8, BLOCK_BYTES + 1, ST_OK);
        send_block(16'd9, 63, ST_OK);
        send_block(16'd10, 70, ST_ABSENT);
    endtask

    // Sender holds off until the unit has returned everything
    task automatic test_drain_pause();
        send_block(random_block(), BLOCK_BYTES, random_verdict());
        wait_drained();
        send_block(random_block(), BLOCK_BYTES, random_verdict());
    endtask

    // Random mix: mostly whole blocks, some broken blocks and noise
    task automatic test_random_traffic();
        int pick;
        while (items_sent < ITEM_TARGET - CALM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_block(random_block(), BLOCK_BYTES, random_verdict());
            end
            else if (pick == 7)
            begin
                send_block(random_block(), $urandom_range(0, 70), random_verdict());
            end
            else
            begin
                repeat ($urandom_range(1, 8)) send_noise();
            end
            // stretch without any idling now and then
            if ($urandom_range(0, 9) == 0)
            begin
                quiet = ~quiet;
            end
        end
        quiet = 1'b0;
    endtask

    // Back-to-back blocks at full rate on both sides
    task automatic test_full_rate();
        quiet = 1'b1;
        repeat (10) send_block(random_block(), BLOCK_BYTES, random_verdict());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_block_verdicts();
        test_drain_pause();
        test_random_traffic();
        test_full_rate();

        wait_drained();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected response beats never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("tb_pak_block_address_and_crc_check: done, clean");
        end
        else
        begin
            $display("tb_pak_block_address_and_crc_check: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
